// ----- rtl/ctt_pkg.sv -----
// Cam tooth capture tracker: shared types, constants and a helper function.
// No dependencies; compiled first.
`default_nettype none

package ctt_pkg;

  localparam int HISTORY_DEPTH = 4;
  localparam int ANGLE_W       = 13;
  localparam int NUM_OFFSETS   = 4;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 13'd7679;
  localparam logic [15:0]        TIME_MAX  = 16'hFFFF;

  // x / 6 == (x * 87382) >> 19 for any 16-bit x
  localparam logic [16:0] DIV6_MUL   = 17'd87382;
  localparam int          DIV6_SHIFT = 19;

  // y / 625 == (y * 109951163) >> 36 for any y below 2^26
  localparam logic [26:0] RECIP625_MUL   = 27'd109951163;
  localparam int          RECIP625_SHIFT = 36;

  // Inputs at or above these give a quotient above 65535
  localparam logic [31:0] INTERVAL_SAT = 32'd2560000;
  localparam logic [31:0] PRODUCT_SAT  = 32'd1706667;

  typedef enum logic [2:0] {
    REG_INIT_MODE   = 3'd0,
    REG_TEETH_M1    = 3'd1,
    REG_CYLINDERS   = 3'd2,
    REG_MAX_GAP     = 3'd3,
    REG_PERIOD_MULT = 3'd4,
    REG_OFFSETS     = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TIME,
    ST_LIMIT,
    ST_INDEX
  } ctrl_state_t;

  typedef struct packed {
    logic        init_from_cylinders;
    logic [1:0]  teeth_minus_one;
    logic [3:0]  cylinder_count;
    logic [15:0] max_front_gap;
    logic [15:0] period_multiplier;
    logic [63:0] cam_offsets_packed;
  } cfg_t;

  typedef struct packed {
    logic load;      // latch the input item
    logic do_time;   // angle, interval scaling, period product
    logic do_limit;  // missing-tooth limit, history shift
    logic commit;    // update index state and load the result register
  } ctt_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctt_status_t;

  // v mod (tm1 + 1); mod 3 by reciprocal, floor(v/3) == (v*11) >> 5 for v < 32
  function automatic logic [1:0] mod_teeth(input logic [4:0] v, input logic [1:0] tm1);
    logic [9:0] prod;
    logic [4:0] q3;
    logic [4:0] r3;
    logic [1:0] res;
    prod = {5'd0, v} * 10'd11;
    q3   = prod[9:5];
    r3   = v - (q3 + {q3[3:0], 1'b0});
    unique case (tm1)
      2'd0:    res = 2'd0;
      2'd1:    res = {1'b0, v[0]};
      2'd2:    res = r3[1:0];
      default: res = v[1:0];
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ctt_if.sv -----
// Valid/ready channel interfaces for tooth samples and tracker results.
// Depends on ctt_pkg.
`default_nettype none

interface ctt_sample_if
  import ctt_pkg::*;
();
  logic        valid;
  logic        ready;
  logic [15:0] raw_angle;
  logic [31:0] raw_interval;
  logic [15:0] engine_period;
  logic        check_missing;

  modport source (output valid, raw_angle, raw_interval, engine_period, check_missing,
                  input ready);
  modport sink   (input valid, raw_angle, raw_interval, engine_period, check_missing,
                  output ready);
endinterface

interface ctt_result_if
  import ctt_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] measured_angle;
  logic [15:0]        tooth_time;
  logic [1:0]         tooth_index;
  logic               missing_tooth;

  modport source (output valid, measured_angle, tooth_time, tooth_index, missing_tooth,
                  input ready);
  modport sink   (input valid, measured_angle, tooth_time, tooth_index, missing_tooth,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/ctt_cfg_regs.sv -----
// APB-style configuration register bank of the cam tooth tracker.
// Depends on ctt_pkg.
`default_nettype none

module ctt_cfg_regs
  import ctt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic     wr_en;
  cfg_reg_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = cfg_reg_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.init_from_cylinders <= 1'b0;
      cfg.teeth_minus_one     <= 2'd3;
      cfg.cylinder_count      <= 4'd4;
      cfg.max_front_gap       <= 16'd7680;
      cfg.period_multiplier   <= 16'd1;
      cfg.cam_offsets_packed  <= 64'd0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_INIT_MODE:   cfg.init_from_cylinders <= pwdata[0];
        REG_TEETH_M1:    cfg.teeth_minus_one     <= pwdata[1:0];
        REG_CYLINDERS:   cfg.cylinder_count      <= pwdata[3:0];
        REG_MAX_GAP:     cfg.max_front_gap       <= pwdata[15:0];
        REG_PERIOD_MULT: cfg.period_multiplier   <= pwdata[15:0];
        REG_OFFSETS:     cfg.cam_offsets_packed  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_INIT_MODE:   prdata = {63'd0, cfg.init_from_cylinders};
      REG_TEETH_M1:    prdata = {62'd0, cfg.teeth_minus_one};
      REG_CYLINDERS:   prdata = {60'd0, cfg.cylinder_count};
      REG_MAX_GAP:     prdata = {48'd0, cfg.max_front_gap};
      REG_PERIOD_MULT: prdata = {48'd0, cfg.period_multiplier};
      REG_OFFSETS:     prdata = cfg.cam_offsets_packed;
      default:         prdata = 64'd0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/ctt_ctrl.sv -----
// Sequencer of the cam tooth tracker: latch, scale, limit, commit.
// Depends on ctt_pkg.
`default_nettype none

module ctt_ctrl
  import ctt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        sample_valid,
  output logic             sample_ready,
  input  wire ctt_status_t status,
  output ctt_cmd_t         cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (sample_valid) state_next = ST_TIME;
      ST_TIME:  state_next = ST_LIMIT;
      ST_LIMIT: state_next = ST_INDEX;
      ST_INDEX: if (status.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sample_ready = (state == ST_IDLE);
    cmd.load     = (state == ST_IDLE) && sample_valid;
    cmd.do_time  = (state == ST_TIME);
    cmd.do_limit = (state == ST_LIMIT);
    cmd.commit   = (state == ST_INDEX) && status.out_free;
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> state == ST_TIME)
    else $error("accepted sample did not start processing");

  a_wait_for_slot: assert property (@(posedge clk) disable iff (rst)
    state == ST_INDEX && !status.out_free |=> state == ST_INDEX && !sample_ready)
    else $error("left commit state while result slot busy");

  a_commit_frees: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> state == ST_IDLE && sample_ready)
    else $error("sequencer not idle after commit");
`endif

endmodule

`default_nettype wire

// ----- rtl/ctt_datapath.sv -----
// Datapath of the cam tooth tracker: scaling multipliers, angle history,
// tooth index logic and the result register. Depends on ctt_pkg.
`default_nettype none

module ctt_datapath
  import ctt_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire cfg_t         cfg,
  input  wire ctt_cmd_t     cmd,
  output ctt_status_t       status,
  input  wire logic [15:0]  raw_angle,
  input  wire logic [31:0]  raw_interval,
  input  wire logic [15:0]  engine_period,
  input  wire logic         check_missing,
  output logic              result_valid,
  input  wire logic         result_ready,
  output logic [ANGLE_W-1:0] measured_angle,
  output logic [15:0]       tooth_time,
  output logic [1:0]        tooth_index,
  output logic              missing_tooth
);

  // latched item
  logic [15:0] in_angle;
  logic [31:0] in_interval;
  logic [15:0] in_period;
  logic        in_check;

  // intermediate results
  logic [ANGLE_W-1:0] angle_r;
  logic [15:0]        ttime_r;
  logic [15:0]        limit_r;
  logic [31:0]        prod_r;

  // tracker state
  logic [ANGLE_W-1:0] hist [HISTORY_DEPTH];
  logic [1:0]         index_reg;
  logic               missing_flag;

  // scaling
  logic [32:0] angle_prod;
  logic [13:0] angle_q;
  logic [25:0] interval_x16;
  logic [25:0] prod_x24;
  logic [25:0] recip_op;
  logic [52:0] recip_prod;
  logic [15:0] recip_q;
  logic        interval_sat;
  logic        prod_sat;

  // index logic
  logic               full;
  logic [ANGLE_W-1:0] max_hist;
  logic [15:0]        max_off;
  logic [15:0]        gap;
  logic               realign;
  logic [2:0]         idx_inc;
  logic [1:0]         start_mod;
  logic [3:0]         start_val;
  logic               start_neg;
  logic [4:0]         start_sum;
  logic [1:0]         idx_a;
  logic [2:0]         idx_a_inc;
  logic               miss;
  logic [1:0]         idx_next;
  logic               flag_next;

  assign angle_prod   = {17'd0, in_angle} * {16'd0, DIV6_MUL};
  assign angle_q      = angle_prod[32:DIV6_SHIFT];
  assign interval_sat = in_interval >= INTERVAL_SAT;
  assign interval_x16 = {in_interval[21:0], 4'd0};
  assign prod_sat     = prod_r >= PRODUCT_SAT;
  assign prod_x24     = {prod_r[21:0], 4'd0} + {1'b0, prod_r[21:0], 3'd0};

  // one reciprocal multiplier, shared by interval and limit scaling
  assign recip_op   = cmd.do_limit ? prod_x24 : interval_x16;
  assign recip_prod = {27'd0, recip_op} * {26'd0, RECIP625_MUL};
  assign recip_q    = recip_prod[RECIP625_SHIFT+15:RECIP625_SHIFT];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_angle    <= raw_angle;
      in_interval <= raw_interval;
      in_period   <= engine_period;
      in_check    <= check_missing;
    end
    if (cmd.do_time) begin
      angle_r <= (angle_q > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : angle_q[ANGLE_W-1:0];
      ttime_r <= interval_sat ? TIME_MAX : recip_q;
      prod_r  <= {16'd0, in_period} * {16'd0, cfg.period_multiplier};
    end
    if (cmd.do_limit) begin
      limit_r <= prod_sat ? TIME_MAX : recip_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist[i] <= '0;
      end
      index_reg    <= 2'd0;
      missing_flag <= 1'b0;
    end else begin
      if (cmd.do_limit) begin
        hist[0] <= angle_r;
        for (int i = 1; i < HISTORY_DEPTH; i++) begin
          hist[i] <= hist[i-1];
        end
      end
      if (cmd.commit) begin
        index_reg    <= idx_next;
        missing_flag <= flag_next;
      end
    end
  end

  // gap between the largest reference offset and the largest history angle, zero while any history entry is zero
  always_comb begin
    full     = 1'b1;
    max_hist = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (hist[i] == '0) full = 1'b0;
      if (hist[i] > max_hist) max_hist = hist[i];
    end
    max_off = 16'd0;
    for (int i = 0; i < NUM_OFFSETS; i++) begin
      if (cfg.cam_offsets_packed[16*i +: 16] > max_off) begin
        max_off = cfg.cam_offsets_packed[16*i +: 16];
      end
    end
    if (!full) begin
      gap = 16'd0;
    end else if (max_off >= {3'd0, max_hist}) begin
      gap = max_off - {3'd0, max_hist};
    end else begin
      gap = {3'd0, max_hist} - max_off;
    end
    realign = gap >= cfg.max_front_gap;
  end

  always_comb begin
    idx_inc   = {1'b0, index_reg} + 3'd1;
    start_mod = mod_teeth({2'd0, idx_inc}, cfg.teeth_minus_one);
    start_neg = cfg.init_from_cylinders && (cfg.cylinder_count == 4'd0);
    start_val = cfg.init_from_cylinders ? cfg.cylinder_count - 4'd1 : {2'd0, start_mod};
    // negative start only in cylinder init mode with a cylinder count of zero, i.e. -1 + teeth_minus_one
    start_sum = start_neg ? {3'd0, cfg.teeth_minus_one} - 5'd1
                          : {1'b0, start_val} + {3'd0, cfg.teeth_minus_one};
    if (realign) begin
      idx_a = mod_teeth(start_sum, cfg.teeth_minus_one);
    end else if (start_neg) begin
      idx_a = 2'd0;
    end else if (start_val > 4'd3) begin
      idx_a = 2'd3;
    end else begin
      idx_a = start_val[1:0];
    end
    miss      = ttime_r > limit_r;
    idx_a_inc = {1'b0, idx_a} + {2'd0, miss};
    if (in_check) begin
      idx_next  = mod_teeth({2'd0, idx_a_inc}, cfg.teeth_minus_one);
      flag_next = miss;
    end else begin
      idx_next  = idx_a;
      flag_next = missing_flag;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      measured_angle <= angle_r;
      tooth_time     <= ttime_r;
      tooth_index    <= idx_next;
      missing_tooth  <= flag_next;
    end
  end

  assign status.out_free = !result_valid || result_ready;

`ifndef SYNTHESIS
  a_angle_capped: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> measured_angle <= ANGLE_MAX)
    else $error("measured angle above cap");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> result_valid && tooth_index == index_reg && missing_tooth == missing_flag)
    else $error("committed result does not match tracker state");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(measured_angle) &&
      $stable(tooth_time) && $stable(tooth_index) && $stable(missing_tooth))
    else $error("pending result changed before transfer");
`endif

endmodule

`default_nettype wire

// ----- rtl/cam_tooth_capture_tracker.sv -----
// Cam tooth capture tracker: top level.
// Usage:
//   sample channel (valid/ready): one cam tooth event, raw angle, raw interval,
//   engine period and a missing-tooth check enable.
//   result channel (valid/ready): scaled angle, scaled tooth time, tooth index
//   and missing-tooth flag, one result for every sample.
//   APB-style port: six registers at byte addresses 8*i, written in idle time.
// Timing: a sample is taken when the block is idle; the result is registered
//   after the three-step sequence (scale, limit, commit) around the shared
//   reciprocal multiplier. A new sample is taken only after the previous one
//   has committed.
// Stall: the result register holds until transferred; a new sample may be taken
//   while it waits, but its commit step holds until the register frees.
// Reset (rst, synchronous): history, tooth index and missing flag clear,
//   registers return to their defaults, no result pending.
// Depends on ctt_pkg, ctt_if, ctt_cfg_regs, ctt_ctrl, ctt_datapath.
`default_nettype none

module cam_tooth_capture_tracker
  import ctt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  ctt_sample_if.sink       sample,
  ctt_result_if.source     result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready
);

  cfg_t        cfg;
  ctt_cmd_t    cmd;
  ctt_status_t status;
  logic        sample_ready;
  logic        result_valid;
  logic [ANGLE_W-1:0] measured_angle;
  logic [15:0] tooth_time;
  logic [1:0]  tooth_index;
  logic        missing_tooth;

  ctt_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ctt_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample.valid),
    .sample_ready (sample_ready),
    .status       (status),
    .cmd          (cmd)
  );

  ctt_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .status         (status),
    .raw_angle      (sample.raw_angle),
    .raw_interval   (sample.raw_interval),
    .engine_period  (sample.engine_period),
    .check_missing  (sample.check_missing),
    .result_valid   (result_valid),
    .result_ready   (result.ready),
    .measured_angle (measured_angle),
    .tooth_time     (tooth_time),
    .tooth_index    (tooth_index),
    .missing_tooth  (missing_tooth)
  );

  assign sample.ready          = sample_ready;
  assign result.valid          = result_valid;
  assign result.measured_angle = measured_angle;
  assign result.tooth_time     = tooth_time;
  assign result.tooth_index    = tooth_index;
  assign result.missing_tooth  = missing_tooth;

endmodule

`default_nettype wire
